>>> rtl/static_sorted_index_lookup_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the static sorted index lookup block
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef STATIC_SORTED_INDEX_LOOKUP_TOP_MACROS_SVH
`define STATIC_SORTED_INDEX_LOOKUP_TOP_MACROS_SVH

// same-cycle implication
`define SSIL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssil assertion failed");

// next-cycle implication
`define SSIL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssil assertion failed");

`endif

>>> rtl/ssil_pkg.sv
// ---------------------------------------------------------------------------
// ssil_pkg
// Constants, transfer types and function codes for the sorted index lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssil_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int LEAF_SIZE   = 16;
  localparam int LEAF_COUNT  = (TABLE_DEPTH + LEAF_SIZE - 1) / LEAF_SIZE;

  localparam int KEY_W    = 32;
  localparam int POS_W    = 32;
  localparam int IDX_W    = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int LEAF_AW  = $clog2(LEAF_COUNT);
  localparam int LEAF_IW  = $clog2(LEAF_COUNT + 1);
  localparam int SLOT_W   = $clog2(LEAF_SIZE);
  localparam int ENTRY_W  = KEY_W + POS_W;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] entry_key;
    logic [POS_W-1:0]        entry_pos;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] lower_index;
    logic             found;
    logic [POS_W-1:0] match_pos;
  } out_item_t;

endpackage

>>> rtl/static_sorted_index_lookup_top.sv
// A query searches the leaf-high RAM, then the key RAM, for 1024 entries in leaves of 16;
// each search step is one read of the leaf-high RAM, then of the key RAM (one read a cycle).
// Clear, append and unused codes leave the block idle; the next item is taken on the cycle after.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n low, synchronous) empties the table; memories are not cleared and need no pass.
// ---------------------------------------------------------------------------
// static_sorted_index_lookup_top
// Sorted key table with a one-level leaf index and lower-bound query search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module static_sorted_index_lookup_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssil_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssil_pkg::out_item_t out_data
);

  logic                              key_we;
  logic [ssil_pkg::ADDR_W-1:0]       key_waddr;
  logic [ssil_pkg::ENTRY_W-1:0]      key_wdata;
  logic                              key_re;
  logic [ssil_pkg::ADDR_W-1:0]       key_raddr;
  logic [ssil_pkg::ENTRY_W-1:0]      key_rdata;
  logic                              leaf_we;
  logic [ssil_pkg::LEAF_AW-1:0]      leaf_waddr;
  logic [ssil_pkg::KEY_W-1:0]        leaf_wdata;
  logic                              leaf_re;
  logic [ssil_pkg::LEAF_AW-1:0]      leaf_raddr;
  logic [ssil_pkg::KEY_W-1:0]        leaf_rdata;

  ssil_ram #(
    .WIDTH (ssil_pkg::ENTRY_W),
    .DEPTH (ssil_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  ssil_ram #(
    .WIDTH (ssil_pkg::KEY_W),
    .DEPTH (ssil_pkg::LEAF_COUNT)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .re    (leaf_re),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  ssil_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_re     (key_re),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata),
    .leaf_we    (leaf_we),
    .leaf_waddr (leaf_waddr),
    .leaf_wdata (leaf_wdata),
    .leaf_re    (leaf_re),
    .leaf_raddr (leaf_raddr),
    .leaf_rdata (leaf_rdata)
  );

endmodule

>>> rtl/ssil_ram.sv
// ---------------------------------------------------------------------------
// ssil_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ssil_ctrl.sv
// ---------------------------------------------------------------------------
// ssil_ctrl
// Table fill tracking, two-phase halving search sequencer and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "static_sorted_index_lookup_top_macros.svh"

module ssil_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ssil_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ssil_pkg::out_item_t               out_data,
  output logic                              key_we,
  output logic [ssil_pkg::ADDR_W-1:0]       key_waddr,
  output logic [ssil_pkg::ENTRY_W-1:0]      key_wdata,
  output logic                              key_re,
  output logic [ssil_pkg::ADDR_W-1:0]       key_raddr,
  input  logic [ssil_pkg::ENTRY_W-1:0]      key_rdata,
  output logic                              leaf_we,
  output logic [ssil_pkg::LEAF_AW-1:0]      leaf_waddr,
  output logic [ssil_pkg::KEY_W-1:0]        leaf_wdata,
  output logic                              leaf_re,
  output logic [ssil_pkg::LEAF_AW-1:0]      leaf_raddr,
  input  logic [ssil_pkg::KEY_W-1:0]        leaf_rdata
);

  localparam int IDX_W   = ssil_pkg::IDX_W;
  localparam int ADDR_W  = ssil_pkg::ADDR_W;
  localparam int LEAF_AW = ssil_pkg::LEAF_AW;
  localparam int LEAF_IW = ssil_pkg::LEAF_IW;
  localparam int SLOT_W  = ssil_pkg::SLOT_W;
  localparam int KEY_W   = ssil_pkg::KEY_W;
  localparam int POS_W   = ssil_pkg::POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEAF  = 3'd1;
  localparam logic [2:0] S_KEY   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] d;
    d = b - a;
    return a + (d >> 1);
  endfunction

  logic [2:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [LEAF_IW-1:0]      fill_leaf_r, fill_leaf_nxt;
  logic [SLOT_W-1:0]       fill_slot_r, fill_slot_nxt;
  logic signed [KEY_W-1:0] qkey_r, qkey_nxt;
  logic [IDX_W-1:0]        n_r, n_nxt;
  logic [IDX_W-1:0]        leaves_r, leaves_nxt;
  logic [IDX_W-1:0]        lo_r, lo_nxt;
  logic [IDX_W-1:0]        hi_r, hi_nxt;
  logic [IDX_W-1:0]        mid_r, mid_nxt;
  logic [IDX_W-1:0]        res_idx_r, res_idx_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [POS_W-1:0]        res_pos_r, res_pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ssil_pkg::out_item_t     out_data_r, out_data_nxt;

  logic                    in_xfer;
  logic [IDX_W-1:0]        leaves_now;
  logic signed [KEY_W-1:0] cmp_key;
  logic                    less;
  logic [IDX_W-1:0]        step_lo, step_hi;
  logic [IDX_W-1:0]        leaf_s;
  logic [IDX_W:0]          leaf_e_w;
  logic [IDX_W-1:0]        leaf_e;
  logic [KEY_W-1:0]        rd_key;
  logic [POS_W-1:0]        rd_pos;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_key = key_rdata[KEY_W-1:0];
  assign rd_pos = key_rdata[KEY_W +: POS_W];

  assign leaves_now = IDX_W'(fill_leaf_r) + IDX_W'(fill_slot_r != '0);

  assign cmp_key = (state_r == S_LEAF) ? leaf_rdata : rd_key;
  assign less    = cmp_key < qkey_r;
  assign step_lo = less ? (mid_r + IDX_W'(1)) : lo_r;
  assign step_hi = less ? hi_r : mid_r;

  assign leaf_s   = IDX_W'(step_lo * IDX_W'(ssil_pkg::LEAF_SIZE));
  assign leaf_e_w = {1'b0, leaf_s} + (IDX_W+1)'(ssil_pkg::LEAF_SIZE);
  assign leaf_e   = (leaf_e_w > {1'b0, n_r}) ? n_r : leaf_e_w[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_leaf_nxt = fill_leaf_r;
    fill_slot_nxt = fill_slot_r;
    qkey_nxt      = qkey_r;
    n_nxt         = n_r;
    leaves_nxt    = leaves_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_idx_nxt   = res_idx_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    key_we     = 1'b0;
    key_waddr  = cnt_r[ADDR_W-1:0];
    key_wdata  = {in_data.entry_pos, in_data.entry_key};
    key_re     = 1'b0;
    key_raddr  = mid_r[ADDR_W-1:0];
    leaf_we    = 1'b0;
    leaf_waddr = fill_leaf_r[LEAF_AW-1:0];
    leaf_wdata = in_data.entry_key;
    leaf_re    = 1'b0;
    leaf_raddr = mid_r[LEAF_AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.func)
            ssil_pkg::FUNC_CLEAR: begin
              cnt_nxt       = '0;
              fill_leaf_nxt = '0;
              fill_slot_nxt = '0;
            end
            ssil_pkg::FUNC_APPEND: begin
              if (cnt_r < IDX_W'(ssil_pkg::TABLE_DEPTH)) begin
                key_we  = 1'b1;
                leaf_we = 1'b1;
                cnt_nxt = cnt_r + IDX_W'(1);
                if (fill_slot_r == SLOT_W'(ssil_pkg::LEAF_SIZE - 1)) begin
                  fill_slot_nxt = '0;
                  fill_leaf_nxt = fill_leaf_r + LEAF_IW'(1);
                end else begin
                  fill_slot_nxt = fill_slot_r + SLOT_W'(1);
                end
              end
            end
            ssil_pkg::FUNC_QUERY: begin
              qkey_nxt   = in_data.entry_key;
              n_nxt      = cnt_r;
              leaves_nxt = leaves_now;
              lo_nxt     = '0;
              hi_nxt     = leaves_now;
              if (leaves_now == '0) begin
                res_idx_nxt   = '0;
                res_found_nxt = 1'b0;
                res_pos_nxt   = '0;
                state_nxt     = S_OUT;
              end else begin
                mid_nxt    = mid_of('0, leaves_now);
                leaf_re    = 1'b1;
                leaf_raddr = mid_nxt[LEAF_AW-1:0];
                state_nxt  = S_LEAF;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEAF: begin
        lo_nxt = step_lo;
        hi_nxt = step_hi;
        if (step_lo < step_hi) begin
          mid_nxt    = mid_of(step_lo, step_hi);
          leaf_re    = 1'b1;
          leaf_raddr = mid_nxt[LEAF_AW-1:0];
        end else if (step_lo >= leaves_r) begin
          res_idx_nxt   = n_r;
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_OUT;
        end else begin
          lo_nxt    = leaf_s;
          hi_nxt    = leaf_e;
          mid_nxt   = mid_of(leaf_s, leaf_e);
          key_re    = 1'b1;
          key_raddr = mid_nxt[ADDR_W-1:0];
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        lo_nxt = step_lo;
        hi_nxt = step_hi;
        if (step_lo < step_hi) begin
          mid_nxt   = mid_of(step_lo, step_hi);
          key_re    = 1'b1;
          key_raddr = mid_nxt[ADDR_W-1:0];
        end else begin
          res_idx_nxt = step_lo;
          if (step_lo < n_r) begin
            key_re    = 1'b1;
            key_raddr = step_lo[ADDR_W-1:0];
            state_nxt = S_FETCH;
          end else begin
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = S_OUT;
          end
        end
      end
      S_FETCH: begin
        res_found_nxt = (rd_key == qkey_r);
        res_pos_nxt   = (rd_key == qkey_r) ? rd_pos : '0;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.lower_index = res_idx_r;
          out_data_nxt.found       = res_found_r;
          out_data_nxt.match_pos   = res_pos_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_leaf_r <= '0;
      fill_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_leaf_r <= fill_leaf_nxt;
      fill_slot_r <= fill_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qkey_r      <= qkey_nxt;
    n_r         <= n_nxt;
    leaves_r    <= leaves_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_idx_r   <= res_idx_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_data_r  <= out_data_nxt;
  end

  `SSIL_ASSERT_IMPL(a_cnt_in_range, 1'b1, cnt_r <= IDX_W'(ssil_pkg::TABLE_DEPTH))
  `SSIL_ASSERT_IMPL(a_fill_track, 1'b1, cnt_r == IDX_W'(IDX_W'(fill_leaf_r) * IDX_W'(ssil_pkg::LEAF_SIZE) + IDX_W'(fill_slot_r)))
  `SSIL_ASSERT_IMPL(a_key_bound, state_r == S_KEY, (hi_r <= n_r) && (mid_r < hi_r))
  `SSIL_ASSERT_IMPL(a_found_bound, (state_r == S_OUT) && res_found_r, res_idx_r < n_r)
  `SSIL_ASSERT_IMPL(a_no_ram_write_busy, state_r != S_IDLE, !key_we && !leaf_we)
  `SSIL_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_data_r))

endmodule
